// File: hw/rtl/ctc_greedy_decoder_macros.svh
// ----------------------------------------------------------------------------
// CTC greedy decoder assertion macros
// Shared concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CTC_GREEDY_DECODER_MACROS_SVH
`define CTC_GREEDY_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define CTCGD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ctc_greedy_decoder: assertion failed");
// antecedent implies consequent in the same cycle
`define CTCGD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctc_greedy_decoder: assertion failed");
`else
`define CTCGD_ASSERT_ALWAYS(lbl, expr)
`define CTCGD_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/ctcgd_pkg.sv
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types and constants of the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam int unsigned DEF_MAX_CLASSES = 8192;
  localparam int unsigned DEF_MAX_STEPS   = 256;

  localparam int unsigned PROB_W    = 16;  // Q0.16 probability
  localparam int unsigned CHAR_W    = 13;  // emitted index width
  localparam int unsigned TABLE_W   = 14;  // char_table_size register
  localparam int unsigned SUM_W     = 24;  // score accumulator
  localparam int unsigned MEAN_W    = 16;  // reported mean score

  localparam logic [TABLE_W-1:0] TABLE_RESET = 14'd8192;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } ctcgd_state_t;

endpackage

// File: hw/rtl/ctcgd_divider.sv
// ----------------------------------------------------------------------------
// ctcgd_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctcgd_divider #(
  parameter int unsigned DEN_W = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ctcgd_pkg::SUM_W-1:0]   dividend,
  input  logic [DEN_W-1:0]              divisor,
  output logic                          done,
  output logic [ctcgd_pkg::SUM_W-1:0]   quotient
);

  localparam int unsigned NUM_W = ctcgd_pkg::SUM_W;
  localparam int unsigned ITER_W = $clog2(NUM_W);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(NUM_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // shift next dividend bit into partial remainder, try subtract
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      iter_nxt = iter_r + 1'b1;
      if (iter_r == LAST_ITER) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// ctc_greedy_decoder
// Streaming CTC greedy (best path) decoder with mean character score.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one class probability word per cycle, classes in order. in_step_end
//    marks the last class of a time step, in_seq_end (with in_step_end) the
//    last step of a sequence. A word moves when in_valid is high and in_stall
//    is low.
//  - out_*: at most one result word per step end: an emitted character, a
//    sequence summary (mean score or no_chars), or both. Moves on
//    out_valid && !out_stall.
//  - cfg_*: char_table_size, written while the block is idle.
// Throughput: one input word per cycle while in_stall is low. A sequence end
// with characters counted runs the radix-2 divider over 24 quotient bits, so
// that word blocks the input until the divider is done.
// Output: step-end results are registered and appear in the cycle after
// acceptance; a sequence summary that needs the divider appears once it is done.
// Reset: all step and score state cleared, prev winner is blank, table size
// 8192, output empty.
// Stall: the single output register holds its word while out_stall is high;
// the input then stalls until it is taken.
// ----------------------------------------------------------------------------
`include "ctc_greedy_decoder_macros.svh"

module ctc_greedy_decoder #(
  parameter int unsigned MAX_CLASSES = ctcgd_pkg::DEF_MAX_CLASSES,
  parameter int unsigned MAX_STEPS   = ctcgd_pkg::DEF_MAX_STEPS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config
  input  logic                             cfg_wr_en,
  input  logic [ctcgd_pkg::TABLE_W-1:0]    cfg_wr_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ctcgd_pkg::PROB_W-1:0]     in_class_prob,
  input  logic                             in_step_end,
  input  logic                             in_seq_end,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_char_valid,
  output logic [ctcgd_pkg::CHAR_W-1:0]     out_char_index,
  output logic                             out_seq_done,
  output logic [ctcgd_pkg::MEAN_W-1:0]     out_mean_score,
  output logic                             out_no_chars
);

  localparam int unsigned CC_W  = $clog2(MAX_CLASSES + 1); // counter reaches limit
  localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [CC_W-1:0]  CC_LIMIT  = CC_W'(MAX_CLASSES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_STEPS);

  localparam int unsigned PROB_W = ctcgd_pkg::PROB_W;
  localparam int unsigned SUM_W  = ctcgd_pkg::SUM_W;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  ctcgd_pkg::ctcgd_state_t state_r, state_nxt;

  logic [ctcgd_pkg::TABLE_W-1:0] table_size_r;
  logic [PROB_W-1:0]             best_prob_r, best_prob_nxt;
  logic [IDX_W-1:0]              best_idx_r, best_idx_nxt;
  logic [CC_W-1:0]               class_cnt_r, class_cnt_nxt;
  logic [IDX_W-1:0]              prev_idx_r, prev_idx_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_char_valid_r;
  logic [ctcgd_pkg::CHAR_W-1:0]  out_char_index_r;
  logic                          out_seq_done_r;
  logic [ctcgd_pkg::MEAN_W-1:0]  out_mean_r;
  logic                          out_no_chars_r;

  // --------------------------------------------------------------------------
  // Step datapath
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic              in_range;     // class still takes part in argmax
  logic              take;         // this class is the new running max
  logic [PROB_W-1:0] win_prob;
  logic [IDX_W-1:0]  win_idx;
  logic              is_char;      // counted character at this step end
  logic              scored;       // character also enters the score
  logic              emit;
  logic [SUM_W-1:0]  sum_step;
  logic [CNT_W-1:0]  count_step;
  logic              seq_fin;
  logic              need_div;
  logic              load_now;     // result word complete on this accept
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  assign in_acc   = in_valid && !in_stall;
  assign in_range = (class_cnt_r != CC_LIMIT);
  assign take     = in_range && ((class_cnt_r == '0) || (in_class_prob > best_prob_r));

  // winner including the word being accepted
  assign win_prob = take ? in_class_prob : best_prob_r;
  assign win_idx  = take ? class_cnt_r[IDX_W-1:0] : best_idx_r;

  assign is_char  = (win_idx != '0) && (win_idx != prev_idx_r);
  assign scored   = is_char && (count_r != CNT_LIMIT);
  assign emit     = is_char && (32'(win_idx) < 32'(table_size_r));

  assign sum_step   = scored ? (sum_r + SUM_W'(win_prob)) : sum_r;
  assign count_step = scored ? (count_r + 1'b1) : count_r;

  assign seq_fin  = in_acc && in_step_end && in_seq_end;
  assign need_div = seq_fin && (count_step != '0);
  assign load_now = in_acc && in_step_end && (emit || in_seq_end) && !need_div;

  always_comb begin
    best_prob_nxt = best_prob_r;
    best_idx_nxt  = best_idx_r;
    class_cnt_nxt = class_cnt_r;
    prev_idx_nxt  = prev_idx_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    if (in_acc) begin
      if (in_step_end) begin
        best_prob_nxt = '0;
        best_idx_nxt  = '0;
        class_cnt_nxt = '0;
        if (in_seq_end) begin
          // divider has latched the operands; start a fresh sequence
          prev_idx_nxt = '0;
          sum_nxt      = '0;
          count_nxt    = '0;
        end else begin
          prev_idx_nxt = win_idx;
          sum_nxt      = sum_step;
          count_nxt    = count_step;
        end
      end else begin
        best_prob_nxt = win_prob;
        best_idx_nxt  = win_idx;
        if (in_range) begin
          class_cnt_nxt = class_cnt_r + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctcgd_pkg::ST_RUN: begin
        if (need_div) begin
          state_nxt = ctcgd_pkg::ST_DIV;
        end
      end
      ctcgd_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ctcgd_pkg::ST_RUN;
        end
      end
      default: state_nxt = ctcgd_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    unique case (state_r)
      ctcgd_pkg::ST_RUN: begin
        // one-deep output: free, or being drained this cycle
        in_stall  = out_valid_r && out_stall;
        div_start = need_div;
      end
      ctcgd_pkg::ST_DIV: begin
        in_stall  = 1'b1;
        div_start = 1'b0;
      end
      default: begin
        in_stall  = 1'b1;
        div_start = 1'b0;
      end
    endcase
  end

  ctcgd_divider #(
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_step),
    .divisor  (count_step),
    .done     (div_done),
    .quotient (div_quo)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_now || div_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    // char fields are written at the step end; a pending summary keeps them
    if (in_acc && in_step_end) begin
      out_char_valid_r <= emit;
      out_char_index_r <= emit ? ctcgd_pkg::CHAR_W'(win_idx) : '0;
      out_seq_done_r   <= in_seq_end;
      out_mean_r       <= '0;
      out_no_chars_r   <= in_seq_end && !need_div;
    end else if (div_done) begin
      out_mean_r       <= div_quo[ctcgd_pkg::MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctcgd_pkg::ST_RUN;
      table_size_r <= ctcgd_pkg::TABLE_RESET;
      best_prob_r  <= '0;
      best_idx_r   <= '0;
      class_cnt_r  <= '0;
      prev_idx_r   <= '0;
      sum_r        <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        table_size_r <= cfg_wr_data;
      end
      best_prob_r  <= best_prob_nxt;
      best_idx_r   <= best_idx_nxt;
      class_cnt_r  <= class_cnt_nxt;
      prev_idx_r   <= prev_idx_nxt;
      sum_r        <= sum_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = out_char_valid_r;
  assign out_char_index = out_char_index_r;
  assign out_seq_done   = out_seq_done_r;
  assign out_mean_score = out_mean_r;
  assign out_no_chars   = out_no_chars_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // quotient lands only while waiting on it, into an empty output slot
  `CTCGD_ASSERT_IMPLIES(a_div_slot_free, div_done,
                        (state_r == ctcgd_pkg::ST_DIV) && !out_valid_r)
  // a word without a sequence summary must carry a character
  `CTCGD_ASSERT_IMPLIES(a_word_has_payload, out_valid_r && !out_seq_done_r,
                        out_char_valid_r)
  // emitted characters are never blank
  `CTCGD_ASSERT_IMPLIES(a_char_not_blank, out_valid_r && out_char_valid_r,
                        out_char_index_r != '0)
  // summary is either a mean or no_chars, never both
  `CTCGD_ASSERT_IMPLIES(a_no_chars_zero_mean, out_valid_r && out_no_chars_r,
                        out_seq_done_r && (out_mean_r == '0))
  // character count saturates at the step limit
  `CTCGD_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_LIMIT)

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder testbench
// Streams class probability words into ctc_greedy_decoder and scores every
// result word against a cycle-free best-path predictor kept in a small
// scoreboard class. Covers directed corners, an overlong sequence, several
// table sizes and random sequences under varied idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PROB_W          = ctcgd_pkg::PROB_W;
  localparam int unsigned CHAR_W          = ctcgd_pkg::CHAR_W;
  localparam int unsigned TABLE_W         = ctcgd_pkg::TABLE_W;
  localparam int unsigned SUM_W           = ctcgd_pkg::SUM_W;
  localparam int unsigned MEAN_W          = ctcgd_pkg::MEAN_W;
  localparam int unsigned DEF_MAX_CLASSES = ctcgd_pkg::DEF_MAX_CLASSES;
  localparam int unsigned DEF_MAX_STEPS   = ctcgd_pkg::DEF_MAX_STEPS;
  localparam logic [TABLE_W-1:0] TABLE_RESET = ctcgd_pkg::TABLE_RESET;

  // cycles to let the block settle after the last expected result
  localparam int unsigned DRAIN_CYCLES     = 40;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES      = 400;
  // random words per configuration phase
  localparam int unsigned PHASE_WORDS      = 130;
  // a sequence past the count limit
  localparam int unsigned LONG_SEQ_STEPS   = DEF_MAX_STEPS + 44;

  typedef enum logic [1:0] {
    GAPS_SEND_LIGHT,  // sender idles 26 %, receiver 71 %
    GAPS_RECV_LIGHT,  // sender idles 71 %, receiver 26 %
    GAPS_OFF          // nobody idles
  } gap_mode_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_index;
    logic              seq_done;
    logic [MEAN_W-1:0] mean_score;
    logic              no_chars;
  } dec_result_t;

  // --------------------------------------------------------------------------
  // Best-path scoreboard: tracks the decoder state word by word and keeps
  // the result words it must produce, oldest first.
  // --------------------------------------------------------------------------
  class best_path_board;
    dec_result_t       due_results[$];
    logic [PROB_W-1:0] best_prob;
    int unsigned       best_idx;
    int unsigned       cls_cnt;
    int unsigned       prev_win;
    logic [SUM_W-1:0]  score_sum;
    int unsigned       char_cnt;
    logic [TABLE_W-1:0] table_size;
    int unsigned       words, checked, chars_out, seqs, empty_seqs, mismatches;

    function new();
      best_prob  = '0;
      best_idx   = 0;
      cls_cnt    = 0;
      prev_win   = 0;
      score_sum  = '0;
      char_cnt   = 0;
      table_size = TABLE_RESET;
      words = 0; checked = 0; chars_out = 0; seqs = 0; empty_seqs = 0;
      mismatches = 0;
    endfunction

    function void set_table(logic [TABLE_W-1:0] v);
      table_size = v;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // one accepted input word
    function void take_word(logic [PROB_W-1:0] prob, logic step_end, logic seq_end);
      dec_result_t      r;
      int unsigned      win;
      logic             emit;
      logic [SUM_W-1:0] quot;
      words++;
      // classes past the limit are ignored, counter sticks at the limit
      if (cls_cnt < DEF_MAX_CLASSES) begin
        if (cls_cnt == 0 || prob > best_prob) begin
          best_prob = prob;
          best_idx  = cls_cnt;
        end
        cls_cnt++;
      end
      if (!step_end) return;

      win  = best_idx;
      emit = 1'b0;
      if (win != 0 && win != prev_win) begin
        // saturated count: still emitted, no longer scored
        if (char_cnt < DEF_MAX_STEPS) begin
          score_sum = score_sum + best_prob;
          char_cnt++;
        end
        if (win < table_size) emit = 1'b1;
      end
      prev_win  = win;
      best_prob = '0;
      best_idx  = 0;
      cls_cnt   = 0;

      r            = '0;
      r.char_valid = emit;
      r.char_index = emit ? win[CHAR_W-1:0] : '0;
      if (emit) chars_out++;
      if (seq_end) begin
        seqs++;
        r.seq_done = 1'b1;
        if (char_cnt == 0) begin
          r.no_chars = 1'b1;
          empty_seqs++;
        end else begin
          quot         = SUM_W'(score_sum / char_cnt);
          r.mean_score = quot[MEAN_W-1:0];
        end
        prev_win  = 0;
        score_sum = '0;
        char_cnt  = 0;
        due_results = {due_results, r};
      end else if (emit) begin
        due_results = {due_results, r};
      end
    endfunction

    // one accepted result word
    function void match_result(dec_result_t got);
      dec_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cv=%0b idx=%0d done=%0b mean=%h nc=%0b",
                   got.char_valid, got.char_index, got.seq_done, got.mean_score,
                   got.no_chars);
        return;
      end
      want = due_results.pop_front();
      if (got.char_valid !== want.char_valid || got.char_index !== want.char_index ||
          got.seq_done !== want.seq_done || got.mean_score !== want.mean_score ||
          got.no_chars !== want.no_chars) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: want cv=%0b idx=%0d done=%0b mean=%h nc=%0b",
                   checked, want.char_valid, want.char_index, want.seq_done,
                   want.mean_score, want.no_chars);
          $display("result %0d: got  cv=%0b idx=%0d done=%0b mean=%h nc=%0b",
                   checked, got.char_valid, got.char_index, got.seq_done,
                   got.mean_score, got.no_chars);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [TABLE_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PROB_W-1:0]  in_class_prob = '0;
  logic               in_step_end = 1'b0;
  logic               in_seq_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_char_valid;
  logic [CHAR_W-1:0]  out_char_index;
  logic               out_seq_done;
  logic [MEAN_W-1:0]  out_mean_score;
  logic               out_no_chars;

  gap_mode_t      gap_mode = GAPS_SEND_LIGHT;
  logic           hold_arm = 1'b0;   // main asks for the long output hold
  logic           hold_done = 1'b0;
  int unsigned    hold_left = 0;
  best_path_board board;

  ctc_greedy_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_class_prob  (in_class_prob),
    .in_step_end    (in_step_end),
    .in_seq_end     (in_seq_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_valid (out_char_valid),
    .out_char_index (out_char_index),
    .out_seq_done   (out_seq_done),
    .out_mean_score (out_mean_score),
    .out_no_chars   (out_no_chars)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per gap mode, plus one long hold-off counted here
  // so that the output register fills and the block stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      case (gap_mode)
        GAPS_SEND_LIGHT: out_stall <= ($urandom_range(0, 99) < 71);
        GAPS_RECV_LIGHT: out_stall <= ($urandom_range(0, 99) < 26);
        default:         out_stall <= 1'b0;
      endcase
    end
  end

  // Result monitor: values read at the edge are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_result('{out_char_valid, out_char_index, out_seq_done,
                           out_mean_score, out_no_chars});
  end

  // Watchdog, well above the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Offer one word, with random idle cycles first; returns once accepted.
  // Valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_word(input logic [PROB_W-1:0] prob, input logic step_end,
                           input logic seq_end);
    int unsigned gap_pct;
    gap_pct = (gap_mode == GAPS_SEND_LIGHT) ? 26 :
              (gap_mode == GAPS_RECV_LIGHT) ? 71 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_class_prob <= prob;
    in_step_end   <= step_end;
    in_seq_end    <= seq_end;
    do @(posedge clk); while (in_stall);
    board.take_word(prob, step_end, seq_end);
  endtask

  // Drop valid, wait for every expected word, then let the divider settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table(input logic [TABLE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_table(v);
  endtask

  // One well-formed sequence with random content. Each step picks a flavor:
  // free random, heavy ties, a planted winner (often the previous one, to
  // exercise the repeat merge) or a blank winner. Now and then a mid-step
  // word carries a stray seq_end, which must be ignored.
  task automatic play_sequence(input int unsigned n_steps, input int unsigned max_cls);
    int unsigned ncls, win, flavor, last_win;
    logic [PROB_W-1:0] p;
    logic last_cls, qe;
    last_win = 0;
    for (int unsigned s = 0; s < n_steps; s++) begin
      ncls   = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40)
                                            : $urandom_range(1, max_cls);
      flavor = $urandom_range(0, 3);
      win    = (flavor == 2 && last_win < ncls && $urandom_range(0, 1))
               ? last_win : $urandom_range(0, ncls - 1);
      if (flavor == 3) win = 0;
      for (int unsigned c = 0; c < ncls; c++) begin
        case (flavor)
          0: p = PROB_W'($urandom);
          1: begin
            case ($urandom_range(0, 2))
              0:       p = 16'h0000;
              1:       p = 16'h8000;
              default: p = 16'hFFFF;
            endcase
          end
          default: p = (c == win) ? PROB_W'($urandom_range(16'hC000, 16'hFFFF))
                                  : PROB_W'($urandom_range(0, 16'hBFFF));
        endcase
        last_cls = (c == ncls - 1);
        qe = last_cls ? (s == n_steps - 1) : ($urandom_range(0, 31) == 0);
        send_word(p, last_cls, qe);
      end
      last_win = win;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned start_words, max_cls;
    logic [TABLE_W-1:0] tsize;
    board = new();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset table size (8192), sender light / receiver heavy gaps.
    // single-class step, sequence end with nothing counted
    send_word(16'h0000, 1'b1, 1'b1);
    // stray seq_end on a non-final class, then class 1 wins at full scale
    send_word(16'h0000, 1'b0, 1'b1);
    send_word(16'hFFFF, 1'b1, 1'b0);
    // class 1 wins again: merged, no word out
    send_word(16'h1234, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    // blank step
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0001, 1'b1, 1'b0);
    // tie between classes 2 and 3: first maximum wins
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h9000, 1'b0, 1'b0);
    send_word(16'h9000, 1'b1, 1'b0);
    // all-zero step goes to the blank, sequence ends with two characters
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b1);
    // same class twice across a blank counts twice; the last step both
    // emits and closes the sequence
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h4000, 1'b1, 1'b1);

    // Overlong sequence: winners alternate 1/2 so every step counts; the
    // count saturates while characters keep coming out.
    for (int unsigned s = 0; s < LONG_SEQ_STEPS; s++) begin
      send_word(PROB_W'($urandom_range(0, 16'h7FFF)), 1'b0, 1'b0);
      send_word(s[0] ? PROB_W'($urandom_range(0, 16'h7FFF))
                     : PROB_W'($urandom_range(16'h8000, 16'hFFFF)),
                1'b0, 1'b0);
      send_word(s[0] ? PROB_W'($urandom_range(16'h8000, 16'hFFFF))
                     : PROB_W'($urandom_range(0, 16'h7FFF)),
                1'b1, s == LONG_SEQ_STEPS - 1);
    end

    // Random phases: table size and gap mode change only while idle.
    for (int unsigned ph = 0; ph < 6; ph++) begin
      max_cls = 8;
      case (ph)
        0: tsize = '0;                     // nothing emitted, summaries only
        1: tsize = '1;                     // oversized register
        2: tsize = 14'd3;
        3: begin
          tsize   = TABLE_W'($urandom_range(1, 9));
          max_cls = 12;
        end
        4: tsize = TABLE_RESET;
        default: begin
          tsize   = TABLE_W'($urandom_range(0, 12));
          max_cls = 12;
        end
      endcase
      write_table(tsize);
      gap_mode <= (ph < 2) ? GAPS_SEND_LIGHT : (ph < 4) ? GAPS_RECV_LIGHT : GAPS_OFF;
      if (ph == 4) hold_arm <= 1'b1;   // long hold-off while words keep coming
      @(posedge clk);
      start_words = board.words;
      while (board.words - start_words < PHASE_WORDS)
        play_sequence($urandom_range(1, 10), max_cls);
    end

    drain();
    if (board.pending() != 0) begin
      $display("%0d expected results never arrived", board.pending());
      board.mismatches += board.pending();
    end

    $display("run covered %0d input words, %0d result words, %0d characters",
             board.words, board.checked, board.chars_out);
    $display("%0d sequences (%0d empty), tables 0/3/8192/16383/random, %0d-step seq, %0d-cycle hold",
             board.seqs, board.empty_seqs, LONG_SEQ_STEPS, HOLD_CYCLES);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
